[hdl/led_sms_pkg.sv]
// ----------------------------------------------------------------------------
// led_sms_pkg
// shared widths, register indexes and reset values of the led state mirror
// scheduler
// ----------------------------------------------------------------------------
package led_sms_pkg;

  localparam int StateW = 4;
  localparam int PeerW  = 2;
  localparam int TimeW  = 64;
  localparam int GenW   = 32;
  localparam int MsW    = 16;

  localparam int InDataW  = 72;
  localparam int OutDataW = 56;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REFRESH_INTERVAL = 2'd0,
    REG_MIRROR_TTL       = 2'd1,
    REG_LOWEST_SEL       = 2'd2,
    REG_HIGHEST_SEL      = 2'd3
  } cfg_reg_t;

  localparam logic [MsW-1:0]    RefreshReset = 16'd1000;
  localparam logic [MsW-1:0]    TtlReset     = 16'd3000;
  localparam logic [StateW-1:0] LowestReset  = 4'd1;
  localparam logic [StateW-1:0] HighestReset = 4'd4;

  localparam logic [GenW-1:0] GenMax = {GenW{1'b1}};

  // output word bit positions, lowest field first
  localparam int OutStateLo = 0;
  localparam int OutGenLo   = OutStateLo + StateW;
  localparam int OutTtlLo   = OutGenLo + GenW;
  localparam int OutMaskLo  = OutTtlLo + MsW;
  localparam int OutExhBit  = OutMaskLo + PeerW;

endpackage

[hdl/led_state_mirror_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// led_state_mirror_scheduler_unit
// mirrors a requested led state to two peers with generation, ttl and
// periodic refresh scheduling
// ----------------------------------------------------------------------------
// an accepted input word passes the input register, then the result register
// throughput: one word per cycle unless m_tready stalls, set by both registers
// state is updated as a word moves from the input to the result register
// rst is synchronous: clears valids, mirror state and loads register defaults
// ----------------------------------------------------------------------------
module led_state_mirror_scheduler_unit
  import led_sms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // config write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // requested_state, peer_mask, now_ms
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata    // cmd_state, cmd_generation, cmd_ttl,
                                         // peer_send, exhausted
);

  // config registers
  logic [MsW-1:0]    refresh_interval_ms;
  logic [MsW-1:0]    mirror_ttl_ms;
  logic [StateW-1:0] lowest_selectable;
  logic [StateW-1:0] highest_selectable;

  // mirror state
  logic              started;
  logic [StateW-1:0] shown_state;
  logic [GenW-1:0]   generation_count;
  logic              gen_exhausted;
  logic [TimeW-1:0]  last_send_time;
  logic [PeerW-1:0]  prev_peers;

  // input register
  logic              in_valid;
  logic [StateW-1:0] in_req;
  logic [PeerW-1:0]  in_peers;
  logic [TimeW-1:0]  in_now;

  logic out_advance;
  logic in_advance;

  assign out_advance = !m_tvalid || m_tready;
  assign in_advance  = in_valid && out_advance;
  assign s_tready    = !in_valid || out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_interval_ms <= RefreshReset;
      mirror_ttl_ms       <= TtlReset;
      lowest_selectable   <= LowestReset;
      highest_selectable  <= HighestReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REFRESH_INTERVAL: refresh_interval_ms <= cfg_data[MsW-1:0];
        REG_MIRROR_TTL:       mirror_ttl_ms       <= cfg_data[MsW-1:0];
        REG_LOWEST_SEL:       lowest_selectable   <= cfg_data[StateW-1:0];
        REG_HIGHEST_SEL:      highest_selectable  <= cfg_data[StateW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req   <= s_tdata[StateW-1:0];
      in_peers <= s_tdata[StateW +: PeerW];
      in_now   <= s_tdata[StateW+PeerW +: TimeW];
    end
  end

  // update logic
  logic             accepted;
  logic             is_change;
  logic             runs_out;
  logic [TimeW-1:0] elapsed;
  logic             refresh_due;
  logic [PeerW-1:0] fresh;

  logic              started_next;
  logic [StateW-1:0] shown_state_next;
  logic [GenW-1:0]   generation_count_next;
  logic              gen_exhausted_next;
  logic [TimeW-1:0]  last_send_time_next;
  logic [PeerW-1:0]  prev_peers_next;
  logic [OutDataW-1:0] result_next;

  logic [StateW-1:0] r_state;
  logic [GenW-1:0]   r_gen;
  logic [MsW-1:0]    r_ttl;
  logic [PeerW-1:0]  r_mask;
  logic              r_exh;

  assign accepted  = (in_req >= lowest_selectable) && (in_req <= highest_selectable)
                     && !in_now[TimeW-1];
  assign is_change = !started || (shown_state != in_req);
  assign runs_out  = started && (shown_state != in_req) && (generation_count == GenMax);
  assign elapsed   = in_now - last_send_time;
  assign refresh_due = (in_now >= last_send_time)
                       && ((elapsed[TimeW-1:MsW] != '0)
                           || (elapsed[MsW-1:0] >= refresh_interval_ms));
  assign fresh     = in_peers & ~prev_peers;

  always_comb begin
    started_next          = started;
    shown_state_next      = shown_state;
    generation_count_next = generation_count;
    gen_exhausted_next    = gen_exhausted;
    last_send_time_next   = last_send_time;
    prev_peers_next       = prev_peers;
    r_state = '0;
    r_gen   = '0;
    r_ttl   = '0;
    r_mask  = '0;
    r_exh   = 1'b0;
    if (accepted) begin
      if (gen_exhausted || runs_out) begin
        gen_exhausted_next = 1'b1;
        r_state = shown_state;
        r_gen   = generation_count;
        r_ttl   = mirror_ttl_ms;
        r_exh   = 1'b1;
      end else begin
        prev_peers_next = in_peers;
        r_ttl = mirror_ttl_ms;
        if (is_change) begin
          started_next          = 1'b1;
          shown_state_next      = in_req;
          generation_count_next = started ? generation_count + 1'b1 : GenW'(1);
          last_send_time_next   = in_now;
          r_state = in_req;
          r_gen   = started ? generation_count + 1'b1 : GenW'(1);
          r_mask  = in_peers;
        end else begin
          r_state = shown_state;
          r_gen   = generation_count;
          if (refresh_due) begin
            last_send_time_next = in_now;
            r_mask = in_peers;
          end else begin
            r_mask = fresh;
          end
        end
      end
    end
    result_next = {1'b0, r_exh, r_mask, r_ttl, r_gen, r_state};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      shown_state      <= '0;
      generation_count <= '0;
      gen_exhausted    <= 1'b0;
      last_send_time   <= '0;
      prev_peers       <= '0;
    end else if (in_advance) begin
      started          <= started_next;
      shown_state      <= shown_state_next;
      generation_count <= generation_count_next;
      gen_exhausted    <= gen_exhausted_next;
      last_send_time   <= last_send_time_next;
      prev_peers       <= prev_peers_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      m_tdata <= result_next;
    end
  end

endmodule

[hdl/led_sms_checker.sv]
// ----------------------------------------------------------------------------
// led_sms_checker
// port level checks of the led state mirror scheduler result stream
// ----------------------------------------------------------------------------
module led_sms_checker
  import led_sms_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  logic seen_exh;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_exh <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[OutExhBit]) begin
      seen_exh <= 1'b1;
    end
  end

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // exhausted results never send
  a_exh_no_send: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OutExhBit] |-> m_tdata[OutMaskLo +: PeerW] == '0)
    else $error("exhausted result with nonzero send mask");

  // generation zero only on an all zero rejected word
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OutGenLo +: GenW] == '0 |-> m_tdata == '0)
    else $error("rejected result word not all zero");

  // once exhausted, every non rejected result stays exhausted
  a_exh_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_exh && m_tdata[OutGenLo +: GenW] != '0
    |-> m_tdata[OutExhBit])
    else $error("exhausted flag dropped");

endmodule

bind led_state_mirror_scheduler_unit led_sms_checker u_led_sms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[sim/led_state_mirror_scheduler_unit_tb.sv]
// ----------------------------------------------------------------------------
// led_state_mirror_scheduler_unit_tb
// self-checking bench: a directed table of words, then phases of random words
// under several register settings and idle patterns; every result word is
// compared field by field against the table's word or an in-bench mirror scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_state_mirror_scheduler_unit_tb;
  import led_sms_pkg::*;

  typedef struct packed {
    logic              exh;
    logic [PeerW-1:0]  mask;
    logic [MsW-1:0]    ttl;
    logic [GenW-1:0]   gen;
    logic [StateW-1:0] st;
  } mirror_cmd_t;

  typedef struct packed {
    logic [StateW-1:0] req;
    logic [PeerW-1:0]  peers;
    logic [TimeW-1:0]  now;
    logic              typed;
    mirror_cmd_t       want;
  } stim_row_t;

  localparam mirror_cmd_t NoCmd = '0;
  localparam int NumRows = 15;
  localparam int NumPhases = 7;
  localparam int PhaseWords = 170;
  localparam int ChunkWords = 40;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;   // requested_state, peer_mask, now_ms
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;   // cmd_state, cmd_generation, cmd_ttl,
                                  // peer_send, exhausted

  // mirror of the block's registers and state
  logic [MsW-1:0]    refresh_ms;
  logic [MsW-1:0]    ttl_ms;
  logic [StateW-1:0] sel_lo;
  logic [StateW-1:0] sel_hi;
  logic              mir_started;
  logic [StateW-1:0] mir_state;
  logic [GenW-1:0]   mir_gen;
  logic              mir_exhausted;
  logic [TimeW-1:0]  mir_last_send;
  logic [PeerW-1:0]  mir_prev_peers;

  mirror_cmd_t cmd_queue[$];
  int gap_pct;
  int stall_pct;
  int err_cnt;
  int n_words;
  int n_results;
  int n_rejected;
  int n_changes;
  int n_refreshes;

  led_state_mirror_scheduler_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", cmd_queue.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic mirror_cmd_t predict_mirror(input logic [StateW-1:0] req,
                                                 input logic [PeerW-1:0] peers,
                                                 input logic [TimeW-1:0] now);
    mirror_cmd_t c;
    logic changed;
    logic due;
    c = NoCmd;
    changed = 1'b0;
    due = 1'b0;
    if (req < sel_lo || req > sel_hi || now[TimeW-1]) begin
      n_rejected++;
      return c;
    end
    c.st = mir_state;
    c.gen = mir_gen;
    c.ttl = ttl_ms;
    if (mir_exhausted) begin
      c.exh = 1'b1;
      return c;
    end
    if (!mir_started) begin
      mir_started = 1'b1;
      mir_state = req;
      mir_gen = 1;
      mir_last_send = now;
      changed = 1'b1;
    end else if (mir_state != req) begin
      if (mir_gen == GenMax) begin
        mir_exhausted = 1'b1;
        c.exh = 1'b1;
        return c;
      end
      mir_state = req;
      mir_gen = mir_gen + 1;
      mir_last_send = now;
      changed = 1'b1;
    end
    if (!changed && now >= mir_last_send &&
        now - mir_last_send >= {48'd0, refresh_ms}) begin
      mir_last_send = now;
      due = 1'b1;
    end
    n_changes += changed;
    n_refreshes += due;
    c.st = mir_state;
    c.gen = mir_gen;
    c.mask = (changed || due) ? peers : (peers & ~mir_prev_peers);
    mir_prev_peers = peers;
    return c;
  endfunction

  task automatic flag_error(input string what, input mirror_cmd_t want,
                            input mirror_cmd_t got);
    if (err_cnt < 10) begin
      $display("%0t %s: exp st=%0d gen=%0d ttl=%0d mask=%0d exh=%0b", $time, what,
               want.st, want.gen, want.ttl, want.mask, want.exh);
      $display("%0t %s: got st=%0d gen=%0d ttl=%0d mask=%0d exh=%0b", $time, what,
               got.st, got.gen, got.ttl, got.mask, got.exh);
    end
    err_cnt++;
  endtask

  always @(posedge clk) begin
    mirror_cmd_t got;
    mirror_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OutExhBit:0];
      n_results++;
      if (cmd_queue.size() == 0) begin
        flag_error("unexpected word", NoCmd, got);
      end else begin
        want = cmd_queue.pop_front();
        if (got.st !== want.st || got.gen !== want.gen || got.ttl !== want.ttl ||
            got.mask !== want.mask || got.exh !== want.exh)
          flag_error("mismatch", want, got);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst)
      m_tready = ($urandom_range(99, 0) >= stall_pct);
  end

  // called right after a falling edge, returns right after one
  task automatic send_word(input logic [StateW-1:0] req, input logic [PeerW-1:0] peers,
                           input logic [TimeW-1:0] now, input logic typed,
                           input mirror_cmd_t want);
    mirror_cmd_t pred;
    while ($urandom_range(99, 0) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {2'b00, now, peers, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = predict_mirror(req, peers, now);
    cmd_queue.push_back(typed ? want : pred);
    n_words++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid = 1'b0;
    while (cmd_queue.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_REFRESH_INTERVAL: refresh_ms = val;
      REG_MIRROR_TTL:       ttl_ms = val;
      REG_LOWEST_SEL:       sel_lo = val[StateW-1:0];
      REG_HIGHEST_SEL:      sel_hi = val[StateW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_idle(input int mode);
    case (mode % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 76; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 76; end
      default: begin gap_pct = 33; stall_pct = 33; end
    endcase
  endtask

  initial begin
    stim_row_t dir_tab [0:NumRows-1];
    logic [StateW-1:0] req;
    logic [StateW-1:0] cur_req;
    logic [PeerW-1:0] peers;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] clock_ms;
    int pick;
    int step;
    int lo_pick;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_REFRESH_INTERVAL;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    err_cnt = 0;
    n_words = 0;
    n_results = 0;
    n_rejected = 0;
    n_changes = 0;
    n_refreshes = 0;
    refresh_ms = RefreshReset;
    ttl_ms = TtlReset;
    sel_lo = LowestReset;
    sel_hi = HighestReset;
    mir_started = 1'b0;
    mir_state = '0;
    mir_gen = '0;
    mir_exhausted = 1'b0;
    mir_last_send = '0;
    mir_prev_peers = '0;

    // state below the range, above it, negative time, then first valid word
    dir_tab[0]  = {4'd0,  2'd3, 64'd0,                    1'b1, NoCmd};
    dir_tab[1]  = {4'd5,  2'd3, 64'd100,                  1'b1, NoCmd};
    dir_tab[2]  = {4'd2,  2'd3, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, NoCmd};
    dir_tab[3]  = {4'd1,  2'd1, 64'd0,                    1'b1,
                   1'b0, 2'd1, 16'd3000, 32'd1, 4'd1};
    // newly connected peer, refresh just short of and at the interval
    dir_tab[4]  = {4'd1,  2'd3, 64'd10,                   1'b0, NoCmd};
    dir_tab[5]  = {4'd1,  2'd3, 64'd999,                  1'b0, NoCmd};
    dir_tab[6]  = {4'd1,  2'd3, 64'd1000,                 1'b0, NoCmd};
    // time going backwards, then a change
    dir_tab[7]  = {4'd1,  2'd0, 64'd500,                  1'b0, NoCmd};
    dir_tab[8]  = {4'd4,  2'd2, 64'd600,                  1'b0, NoCmd};
    dir_tab[9]  = {4'd4,  2'd3, 64'd100,                  1'b0, NoCmd};
    dir_tab[10] = {4'd4,  2'd3, 64'h7FFF_FFFF_FFFF_FFFF,  1'b0, NoCmd};
    dir_tab[11] = {4'd3,  2'd3, 64'h8000_0000_0000_0000,  1'b1, NoCmd};
    dir_tab[12] = {4'd3,  2'd0, 64'h7FFF_FFFF_FFFF_FFFF,  1'b0, NoCmd};
    dir_tab[13] = {4'd15, 2'd3, 64'd5,                    1'b1, NoCmd};
    dir_tab[14] = {4'd2,  2'd3, 64'd0,                    1'b0, NoCmd};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NumRows; i++)
      send_word(dir_tab[i].req, dir_tab[i].peers, dir_tab[i].now, dir_tab[i].typed,
                dir_tab[i].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      repeat (6) @(negedge clk);
      case (ph)
        1: begin
          write_reg(REG_REFRESH_INTERVAL, 16'd0);
          write_reg(REG_MIRROR_TTL, 16'hFFFF);
          write_reg(REG_LOWEST_SEL, 16'd0);
          write_reg(REG_HIGHEST_SEL, 16'd15);
        end
        2: begin
          write_reg(REG_REFRESH_INTERVAL, 16'hFFFF);
          write_reg(REG_MIRROR_TTL, 16'd0);
          write_reg(REG_LOWEST_SEL, 16'd15);
          write_reg(REG_HIGHEST_SEL, 16'd15);
        end
        3: begin
          write_reg(REG_REFRESH_INTERVAL, 16'($urandom_range(300, 0)));
          write_reg(REG_MIRROR_TTL, 16'($urandom));
          write_reg(REG_LOWEST_SEL, 16'd3);
          write_reg(REG_HIGHEST_SEL, 16'd9);
        end
        4: begin
          // empty selectable range
          write_reg(REG_REFRESH_INTERVAL, 16'd5);
          write_reg(REG_MIRROR_TTL, 16'd7);
          write_reg(REG_LOWEST_SEL, 16'd9);
          write_reg(REG_HIGHEST_SEL, 16'd2);
        end
        5: begin
          lo_pick = $urandom_range(15, 0);
          write_reg(REG_REFRESH_INTERVAL, 16'($urandom_range(3000, 0)));
          write_reg(REG_MIRROR_TTL, 16'($urandom));
          write_reg(REG_LOWEST_SEL, 16'(lo_pick));
          write_reg(REG_HIGHEST_SEL, 16'($urandom_range(15, lo_pick)));
        end
        6: begin
          write_reg(REG_REFRESH_INTERVAL, RefreshReset);
          write_reg(REG_MIRROR_TTL, TtlReset);
          write_reg(REG_LOWEST_SEL, 16'(LowestReset));
          write_reg(REG_HIGHEST_SEL, 16'(HighestReset));
        end
        default: ;
      endcase

      clock_ms = 64'($urandom_range(5000, 0));
      cur_req = (sel_lo <= sel_hi) ? 4'($urandom_range(sel_hi, sel_lo))
                                   : 4'($urandom_range(15, 0));
      for (int k = 0; k < PhaseWords; k++) begin
        if (k % ChunkWords == 0)
          set_idle(ph + k / ChunkWords);
        if ($urandom_range(199, 0) == 0)
          drain_results();
        pick = $urandom_range(99, 0);
        peers = 2'($urandom_range(3, 0));
        req = cur_req;
        if (pick < 70) begin
          if ($urandom_range(99, 0) < 35 && sel_lo <= sel_hi)
            cur_req = 4'($urandom_range(sel_hi, sel_lo));
          req = cur_req;
          if ($urandom_range(3, 0) == 0)
            step = int'(refresh_ms);
          else
            step = $urandom_range(2 * int'(refresh_ms) + 2, 0);
          clock_ms = clock_ms + 64'(step);
          if (clock_ms[TimeW-1])
            clock_ms = 64'($urandom_range(1000, 0));
          now = clock_ms;
        end else if (pick < 80) begin
          step = $urandom_range(int'(refresh_ms) + 1, 1);
          now = (clock_ms > 64'(step)) ? clock_ms - 64'(step) : '0;
        end else if (pick < 88) begin
          now = {$urandom, $urandom};
          now[TimeW-1] = 1'b1;
        end else if (pick < 95) begin
          req = 4'($urandom_range(15, 0));
          now = clock_ms;
        end else begin
          now = {$urandom, $urandom};
          now[TimeW-1] = 1'b0;
        end
        send_word(req, peers, now, 1'b0, NoCmd);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("sent %0d words over %0d register phases, checked %0d results", n_words,
             NumPhases, n_results);
    $display("rejected %0d, state changes %0d, refreshes %0d, errors %0d", n_rejected,
             n_changes, n_refreshes, err_cnt);
    if (err_cnt == 0 && cmd_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
